// ===== rtl/core/rbq_pkg.sv =====
package rbq_pkg;

   localparam int DEPTH_DEF       = 256;
   localparam int ID_BITS_DEF     = 32;
   localparam int HANDLE_BITS_DEF = 16;

   localparam int CAP_W    = 9;
   localparam int ID_W     = 32;
   localparam int HANDLE_W = 16;
   localparam int METRIC_W = 16;
   localparam int OCC_W    = 9;
   localparam int DROP_W   = 64;

   typedef enum logic [1:0] {
      ACT_ENQUEUE  = 2'd0,
      ACT_DISPATCH = 2'd1,
      ACT_ACK      = 2'd2,
      ACT_RESET    = 2'd3
   } rbq_action_type;

   typedef enum logic [3:0] {
      ST_ENQUEUED      = 4'd0,
      ST_DROPPED       = 4'd1,
      ST_ALL_IN_FLIGHT = 4'd2,
      ST_INVALID       = 4'd3,
      ST_DUPLICATE     = 4'd4,
      ST_DISPATCHED    = 4'd5,
      ST_NONE_PENDING  = 4'd6,
      ST_ACKED         = 4'd7,
      ST_NOT_FOUND     = 4'd8,
      ST_RESET_DONE    = 4'd9
   } rbq_status_type;

   typedef enum logic {
      S_IDLE  = 1'b0,
      S_APPLY = 1'b1
   } rbq_state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch transaction and compare vectors
      logic apply;     // update cells, load response register
   } rbq_cmd_type;

endpackage

// ===== rtl/core/rbq_ctrl.sv =====
module rbq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rbq_pkg::rbq_cmd_type cmd
);

   rbq_pkg::rbq_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rbq_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_stall   = 1'b1;
      cmd.capture = 1'b0;
      cmd.apply   = 1'b0;
      case (state_ff)
         rbq_pkg::S_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = rbq_pkg::S_APPLY;
            end
         end
         rbq_pkg::S_APPLY: begin
            // wait for the response register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.apply = 1'b1;
               state_in  = rbq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rbq_pkg::S_IDLE;
         end
      endcase
      if (cmd.apply) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_apply_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |=> rsp_valid_ff) else $error("response not raised after apply");
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rbq_pkg::S_APPLY) |-> req_stall) else $error("accept while busy");
   a_apply_follows_capture: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == rbq_pkg::S_APPLY)) else $error("capture lost");

endmodule

// ===== rtl/core/rbq_datapath.sv =====
module rbq_datapath #(
   parameter int DEPTH       = rbq_pkg::DEPTH_DEF,
   parameter int ID_BITS     = rbq_pkg::ID_BITS_DEF,
   parameter int HANDLE_BITS = rbq_pkg::HANDLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rbq_pkg::rbq_cmd_type          cmd,
   input  logic                          csr_we,
   input  logic [rbq_pkg::CAP_W-1:0]     csr_wdata,
   input  logic [1:0]                    req_action,
   input  logic [rbq_pkg::ID_W-1:0]      req_batch_id,
   input  logic                          req_batch_id_present,
   input  logic                          req_client_id_present,
   input  logic [rbq_pkg::METRIC_W-1:0]  req_metric_count,
   input  logic [rbq_pkg::HANDLE_W-1:0]  req_payload_handle,
   output logic [3:0]                    rsp_status,
   output logic [rbq_pkg::ID_W-1:0]      rsp_out_batch_id,
   output logic [rbq_pkg::HANDLE_W-1:0]  rsp_out_payload_handle,
   output logic [rbq_pkg::OCC_W-1:0]     rsp_occupancy,
   output logic [rbq_pkg::DROP_W-1:0]    rsp_drop_count
);

   localparam int CNT_BITS = $clog2(DEPTH + 1);

   // entry cells, position 0 oldest
   logic [ID_BITS-1:0]     id_ff [DEPTH];
   logic [ID_BITS-1:0]     id_in [DEPTH];
   logic [HANDLE_BITS-1:0] hd_ff [DEPTH];
   logic [HANDLE_BITS-1:0] hd_in [DEPTH];
   logic [DEPTH-1:0]       fl_ff, fl_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [63:0]            drops_ff, drops_in;
   logic [rbq_pkg::CAP_W-1:0] cap_ff;

   // captured transaction
   rbq_pkg::rbq_action_type act_ff;
   logic [ID_BITS-1:0]     rid_ff;
   logic [HANDLE_BITS-1:0] rhd_ff;
   logic                   ok_ff, idp_ff;
   logic [DEPTH-1:0]       hit_ff, pend_ff;
   logic [DEPTH-1:0]       hit_in, pend_in;
   logic [ID_BITS-1:0]     req_id_rs;

   // response register
   rbq_pkg::rbq_status_type st_ff, st_in;
   logic [rbq_pkg::ID_W-1:0]     oid_ff, oid_in;
   logic [rbq_pkg::HANDLE_W-1:0] ohd_ff, ohd_in;

   logic [DEPTH-1:0]       sel, ge, first;
   logic                   any_hit, any_pend, full;
   logic                   do_remove, do_insert, do_mark, do_clear, do_drop;
   logic [CNT_BITS-1:0]    cnt_rm;
   logic [ID_BITS-1:0]     sel_id;
   logic [HANDLE_BITS-1:0] sel_hd;
   logic [31:0]            eff_cap;

   assign req_id_rs = ID_BITS'(req_batch_id);

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         hit_in[i]  = (CNT_BITS'(i) < cnt_ff) && (id_ff[i] == req_id_rs);
         pend_in[i] = (CNT_BITS'(i) < cnt_ff) && !fl_ff[i];
      end
   end

   always_comb begin
      eff_cap  = ((cap_ff == '0) || (32'(cap_ff) > 32'(DEPTH))) ? 32'(DEPTH) : 32'(cap_ff);
      full     = 32'(cnt_ff) >= eff_cap;
      any_hit  = |hit_ff;
      any_pend = |pend_ff;
      sel      = (act_ff == rbq_pkg::ACT_ACK) ? hit_ff : pend_ff;
      // positions at or above the lowest set bit, and that bit alone
      ge       = ~((sel - DEPTH'(1)) & ~sel);
      first    = ge & ~(ge << 1);
      sel_id   = '0;
      sel_hd   = '0;
      for (int i = 0; i < DEPTH; i++) begin
         sel_id = sel_id | (first[i] ? id_ff[i] : '0);
         sel_hd = sel_hd | (first[i] ? hd_ff[i] : '0);
      end

      do_remove = 1'b0;
      do_insert = 1'b0;
      do_mark   = 1'b0;
      do_clear  = 1'b0;
      do_drop   = 1'b0;
      oid_in    = '0;
      ohd_in    = '0;
      st_in     = rbq_pkg::ST_RESET_DONE;
      case (act_ff)
         rbq_pkg::ACT_ENQUEUE: begin
            if (!ok_ff) begin
               st_in = rbq_pkg::ST_INVALID;
            end else if (any_hit) begin
               st_in = rbq_pkg::ST_DUPLICATE;
            end else if (full) begin
               do_drop = 1'b1;
               if (!any_pend) begin
                  st_in = rbq_pkg::ST_ALL_IN_FLIGHT;
               end else begin
                  st_in     = rbq_pkg::ST_DROPPED;
                  do_remove = 1'b1;
                  do_insert = 1'b1;
               end
            end else begin
               st_in     = rbq_pkg::ST_ENQUEUED;
               do_insert = 1'b1;
            end
         end
         rbq_pkg::ACT_DISPATCH: begin
            if (any_pend) begin
               st_in   = rbq_pkg::ST_DISPATCHED;
               do_mark = 1'b1;
               oid_in  = rbq_pkg::ID_W'(sel_id);
               ohd_in  = rbq_pkg::HANDLE_W'(sel_hd);
            end else begin
               st_in = rbq_pkg::ST_NONE_PENDING;
            end
         end
         rbq_pkg::ACT_ACK: begin
            if (idp_ff && any_hit) begin
               st_in     = rbq_pkg::ST_ACKED;
               do_remove = 1'b1;
            end else begin
               st_in = rbq_pkg::ST_NOT_FOUND;
            end
         end
         default: begin
            st_in    = rbq_pkg::ST_RESET_DONE;
            do_clear = 1'b1;
         end
      endcase

      cnt_rm   = cnt_ff - CNT_BITS'(do_remove);
      cnt_in   = cnt_rm + CNT_BITS'(do_insert);
      drops_in = drops_ff + 64'(do_drop);

      for (int i = 0; i < DEPTH; i++) begin
         id_in[i] = id_ff[i];
         hd_in[i] = hd_ff[i];
         fl_in[i] = fl_ff[i] && !do_clear;
         if (do_mark && first[i]) begin
            fl_in[i] = 1'b1;
         end
         if (do_remove && ge[i] && (i < DEPTH - 1)) begin
            id_in[i] = id_ff[(i + 1) % DEPTH];
            hd_in[i] = hd_ff[(i + 1) % DEPTH];
            fl_in[i] = fl_ff[(i + 1) % DEPTH];
         end
         if (do_insert && (CNT_BITS'(i) == cnt_rm)) begin
            id_in[i] = rid_ff;
            hd_in[i] = rhd_ff;
            fl_in[i] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fl_ff    <= '0;
         cnt_ff   <= '0;
         drops_ff <= '0;
         cap_ff   <= '0;
      end else begin
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
         if (cmd.apply) begin
            fl_ff    <= fl_in;
            cnt_ff   <= cnt_in;
            drops_ff <= drops_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         for (int i = 0; i < DEPTH; i++) begin
            id_ff[i] <= id_in[i];
            hd_ff[i] <= hd_in[i];
         end
         st_ff  <= st_in;
         oid_ff <= oid_in;
         ohd_ff <= ohd_in;
      end
      if (cmd.capture) begin
         act_ff  <= rbq_pkg::rbq_action_type'(req_action);
         rid_ff  <= req_id_rs;
         rhd_ff  <= HANDLE_BITS'(req_payload_handle);
         ok_ff   <= req_batch_id_present && req_client_id_present && (req_metric_count != '0);
         idp_ff  <= req_batch_id_present;
         hit_ff  <= hit_in;
         pend_ff <= pend_in;
      end
   end

   assign rsp_status             = st_ff;
   assign rsp_out_batch_id       = oid_ff;
   assign rsp_out_payload_handle = ohd_ff;
   assign rsp_occupancy          = rbq_pkg::OCC_W'(cnt_ff);
   assign rsp_drop_count         = drops_ff;

   a_unique_ids: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |-> $onehot0(hit_ff)) else $error("duplicate ID held");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= 32'(DEPTH)) else $error("occupancy above depth");
   a_remove_nonempty: assert property (@(posedge clock) disable iff (reset)
      (cmd.apply && do_remove) |-> (cnt_ff != '0)) else $error("remove from empty queue");

endmodule

// ===== rtl/core/retaining_batch_queue_core.sv =====
// Response: capture at the accepting edge, then the response register loads
//   at the apply edge; apply waits while an earlier response is still stalled.
// A new request waits until the last one applies; compare vectors are latched
//   at accept, and the single apply step shifts/inserts over the cell row.
// Synchronous active-high reset empties the queue, clears every in-flight
//   mark, the drop counter and capacity; no clearing pass, ready at once.
module retaining_batch_queue_core #(
   parameter int DEPTH       = rbq_pkg::DEPTH_DEF,
   parameter int ID_BITS     = rbq_pkg::ID_BITS_DEF,
   parameter int HANDLE_BITS = rbq_pkg::HANDLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration: capacity register
   input  logic                          csr_we,
   input  logic [rbq_pkg::CAP_W-1:0]     csr_wdata,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_action,
   input  logic [rbq_pkg::ID_W-1:0]      req_batch_id,
   input  logic                          req_batch_id_present,
   input  logic                          req_client_id_present,
   input  logic [rbq_pkg::METRIC_W-1:0]  req_metric_count,
   input  logic [rbq_pkg::HANDLE_W-1:0]  req_payload_handle,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [3:0]                    rsp_status,
   output logic [rbq_pkg::ID_W-1:0]      rsp_out_batch_id,
   output logic [rbq_pkg::HANDLE_W-1:0]  rsp_out_payload_handle,
   output logic [rbq_pkg::OCC_W-1:0]     rsp_occupancy,
   output logic [rbq_pkg::DROP_W-1:0]    rsp_drop_count
);

   // Controller sequences each transaction; the datapath owns the cell row,
   // counters and the response register. A new request is taken while a
   // finished response still waits; apply holds until that response leaves.
   rbq_pkg::rbq_cmd_type cmd;

   rbq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Cells are age ordered; removal closes the gap by shifting younger
   // entries toward the head, so the oldest pending entry is the lowest
   // set bit of the pending vector.
   rbq_datapath #(
      .DEPTH       (DEPTH),
      .ID_BITS     (ID_BITS),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .csr_we                 (csr_we),
      .csr_wdata              (csr_wdata),
      .req_action             (req_action),
      .req_batch_id           (req_batch_id),
      .req_batch_id_present   (req_batch_id_present),
      .req_client_id_present  (req_client_id_present),
      .req_metric_count       (req_metric_count),
      .req_payload_handle     (req_payload_handle),
      .rsp_status             (rsp_status),
      .rsp_out_batch_id       (rsp_out_batch_id),
      .rsp_out_payload_handle (rsp_out_payload_handle),
      .rsp_occupancy          (rsp_occupancy),
      .rsp_drop_count         (rsp_drop_count)
   );

endmodule

// ===== dv/tb_retaining_batch_queue_core.sv =====
module tb_retaining_batch_queue_core;

   localparam int DEPTH = rbq_pkg::DEPTH_DEF;
   localparam longint CYCLE_LIMIT = 600000;

   // Each outstanding transaction leaves one expected response behind.
   typedef struct packed {
      logic [3:0]                   status;
      logic [rbq_pkg::ID_W-1:0]     bid;
      logic [rbq_pkg::HANDLE_W-1:0] handle;
      logic [rbq_pkg::OCC_W-1:0]    occupancy;
      logic [rbq_pkg::DROP_W-1:0]   drops;
   } rsp_rec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [rbq_pkg::CAP_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_action = '0;
   logic [rbq_pkg::ID_W-1:0] req_batch_id = '0;
   logic req_batch_id_present = 1'b0;
   logic req_client_id_present = 1'b0;
   logic [rbq_pkg::METRIC_W-1:0] req_metric_count = '0;
   logic [rbq_pkg::HANDLE_W-1:0] req_payload_handle = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [3:0] rsp_status;
   logic [rbq_pkg::ID_W-1:0] rsp_out_batch_id;
   logic [rbq_pkg::HANDLE_W-1:0] rsp_out_payload_handle;
   logic [rbq_pkg::OCC_W-1:0] rsp_occupancy;
   logic [rbq_pkg::DROP_W-1:0] rsp_drop_count;

   retaining_batch_queue_core dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall), .req_action(req_action),
      .req_batch_id(req_batch_id), .req_batch_id_present(req_batch_id_present),
      .req_client_id_present(req_client_id_present),
      .req_metric_count(req_metric_count), .req_payload_handle(req_payload_handle),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_out_batch_id(rsp_out_batch_id),
      .rsp_out_payload_handle(rsp_out_payload_handle),
      .rsp_occupancy(rsp_occupancy), .rsp_drop_count(rsp_drop_count)
   );

   always #2 clock = ~clock;

   // Shadow copy of the queue, oldest entry at index 0.
   logic [rbq_pkg::ID_W-1:0]     q_id     [DEPTH];
   logic [rbq_pkg::HANDLE_W-1:0] q_handle [DEPTH];
   logic                         q_flight [DEPTH];
   int unsigned                  q_count;
   logic [rbq_pkg::DROP_W-1:0]   q_drops;
   logic [rbq_pkg::CAP_W-1:0]    q_cap;

   rsp_rec_type pending_rsp[$];
   int  error_count = 0;
   longint cycle_count = 0;
   bit  rsp_gaps_on = 1'b1;   // lets stretches run with no stalls
   int  rsp_wait = 0;         // stall cycles left for the current response

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %0h want %0h (cycle %0d)", what, got, want, cycle_count);
      error_count++;
   endtask

   function automatic int find_batch(input logic [rbq_pkg::ID_W-1:0] id);
      for (int i = 0; i < q_count; i++)
         if (q_id[i] == id) return i;
      return -1;
   endfunction

   function automatic int first_waiting();
      for (int i = 0; i < q_count; i++)
         if (!q_flight[i]) return i;
      return -1;
   endfunction

   function automatic void drop_entry(input int pos);
      for (int i = pos; i + 1 < q_count; i++) begin
         q_id[i] = q_id[i+1];
         q_handle[i] = q_handle[i+1];
         q_flight[i] = q_flight[i+1];
      end
      q_count--;
   endfunction

   // Applies one transaction to the shadow queue, returns the expected response.
   function automatic rsp_rec_type queue_step(input rbq_pkg::rbq_action_type act,
         input logic [rbq_pkg::ID_W-1:0] id, input logic idp, input logic clp,
         input logic [rbq_pkg::METRIC_W-1:0] metrics,
         input logic [rbq_pkg::HANDLE_W-1:0] hnd);
      rsp_rec_type r;
      int pos;
      int unsigned cap_eff;
      r = '0;
      cap_eff = (q_cap == 0 || q_cap > DEPTH) ? DEPTH : int'(q_cap);
      case (act)
         rbq_pkg::ACT_ENQUEUE: begin
            if (!idp || !clp || metrics == 0) r.status = rbq_pkg::ST_INVALID;
            else if (find_batch(id) >= 0) r.status = rbq_pkg::ST_DUPLICATE;
            else begin
               r.status = rbq_pkg::ST_ENQUEUED;
               if (q_count >= cap_eff) begin
                  pos = first_waiting();
                  q_drops++;
                  if (pos < 0) r.status = rbq_pkg::ST_ALL_IN_FLIGHT;
                  else begin
                     drop_entry(pos);
                     r.status = rbq_pkg::ST_DROPPED;
                  end
               end
               if (r.status != rbq_pkg::ST_ALL_IN_FLIGHT && q_count < DEPTH) begin
                  q_id[q_count] = id;
                  q_handle[q_count] = hnd;
                  q_flight[q_count] = 1'b0;
                  q_count++;
               end
            end
         end
         rbq_pkg::ACT_DISPATCH: begin
            pos = first_waiting();
            if (pos < 0) r.status = rbq_pkg::ST_NONE_PENDING;
            else begin
               q_flight[pos] = 1'b1;
               r.bid = q_id[pos];
               r.handle = q_handle[pos];
               r.status = rbq_pkg::ST_DISPATCHED;
            end
         end
         rbq_pkg::ACT_ACK: begin
            pos = idp ? find_batch(id) : -1;
            if (pos < 0) r.status = rbq_pkg::ST_NOT_FOUND;
            else begin
               drop_entry(pos);
               r.status = rbq_pkg::ST_ACKED;
            end
         end
         default: begin
            for (int i = 0; i < DEPTH; i++) q_flight[i] = 1'b0;
            r.status = rbq_pkg::ST_RESET_DONE;
         end
      endcase
      r.occupancy = q_count[rbq_pkg::OCC_W-1:0];
      r.drops = q_drops;
      return r;
   endfunction

   // Sends one transaction after a random gap; prediction made at acceptance.
   task automatic send_item(input rbq_pkg::rbq_action_type act,
         input logic [rbq_pkg::ID_W-1:0] id, input logic idp, input logic clp,
         input logic [rbq_pkg::METRIC_W-1:0] metrics,
         input logic [rbq_pkg::HANDLE_W-1:0] hnd, input bit gaps = 1'b1);
      int gap;
      rsp_rec_type rec;
      gap = gaps ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_batch_id <= id;
      req_batch_id_present <= idp;
      req_client_id_present <= clp;
      req_metric_count <= metrics;
      req_payload_handle <= hnd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      rec = queue_step(act, id, idp, clp, metrics, hnd);
      pending_rsp = {pending_rsp, rec};
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Only written with the block idle.
   task automatic set_capacity(input logic [rbq_pkg::CAP_W-1:0] cap);
      go_idle();
      csr_we <= 1'b1;
      csr_wdata <= cap;
      @(posedge clock);
      csr_we <= 1'b0;
      q_cap = cap;
   endtask

   task automatic enq(input logic [rbq_pkg::ID_W-1:0] id, input bit gaps = 1'b1);
      send_item(rbq_pkg::ACT_ENQUEUE, id, 1'b1, 1'b1, 16'($urandom_range(1, 65535)),
                16'($urandom_range(0, 65535)), gaps);
   endtask

   // Response checker and stall generator.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected response", 64'(rsp_status), 64'd0);
         end else begin
            rsp_rec_type e;
            e = pending_rsp.pop_front();
            if (rsp_status !== e.status)
               report_mismatch("status", 64'(rsp_status), 64'(e.status));
            if (rsp_out_batch_id !== e.bid)
               report_mismatch("out id", 64'(rsp_out_batch_id), 64'(e.bid));
            if (rsp_out_payload_handle !== e.handle)
               report_mismatch("handle", 64'(rsp_out_payload_handle), 64'(e.handle));
            if (rsp_occupancy !== e.occupancy)
               report_mismatch("occupancy", 64'(rsp_occupancy), 64'(e.occupancy));
            if (rsp_drop_count !== e.drops)
               report_mismatch("drop_count", rsp_drop_count, e.drops);
         end
         // stall wait drawn at random per response
         rsp_wait = rsp_gaps_on ? $urandom_range(0, 12) : 0;
      end else if (rsp_valid && rsp_wait > 0) begin
         rsp_wait = rsp_wait - 1;
      end
      rsp_stall <= rsp_gaps_on && (rsp_wait > 0);
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Field extremes, every action and every status.
   task automatic test_directed();
      send_item(rbq_pkg::ACT_DISPATCH, '0, 1'b0, 1'b0, '0, '0);          // none pending
      send_item(rbq_pkg::ACT_ACK, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
      send_item(rbq_pkg::ACT_ENQUEUE, 32'h1, 1'b0, 1'b1, 16'h1, 16'h1);   // no id
      send_item(rbq_pkg::ACT_ENQUEUE, 32'h1, 1'b1, 1'b0, 16'h1, 16'h1);   // no client
      send_item(rbq_pkg::ACT_ENQUEUE, 32'h1, 1'b1, 1'b1, 16'h0, 16'h1);   // zero metrics
      send_item(rbq_pkg::ACT_ENQUEUE, 32'h0, 1'b1, 1'b1, 16'hFFFF, 16'h0);
      send_item(rbq_pkg::ACT_ENQUEUE, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'h1, 16'hFFFF);
      send_item(rbq_pkg::ACT_ENQUEUE, 32'h0, 1'b1, 1'b1, 16'h5, 16'h5);   // duplicate
      send_item(rbq_pkg::ACT_ACK, 32'h0, 1'b0, 1'b1, 16'h1, 16'h0);       // ack without id
      send_item(rbq_pkg::ACT_DISPATCH, '0, 1'b0, 1'b0, '0, '0);
      send_item(rbq_pkg::ACT_DISPATCH, '0, 1'b0, 1'b0, '0, '0);
      send_item(rbq_pkg::ACT_DISPATCH, '0, 1'b0, 1'b0, '0, '0);
      send_item(rbq_pkg::ACT_RESET, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
      send_item(rbq_pkg::ACT_ACK, 32'h0, 1'b1, 1'b1, 16'h1, 16'h0);
      set_capacity(9'd1);
      enq(32'h10);                                                // full: drop oldest
      send_item(rbq_pkg::ACT_DISPATCH, '0, 1'b0, 1'b0, '0, '0);
      enq(32'h11);                                                // all in flight
      set_capacity(9'd300);                                       // saturates at depth
      enq(32'h12);
   endtask

   // Fill to full built depth with no gaps, then overflow.
   task automatic test_full_depth();
      set_capacity(9'd0);
      rsp_gaps_on = 1'b0;
      for (int i = 0; i < DEPTH + 4; i++) enq(32'h100 + i, 1'b0);
      rsp_gaps_on = 1'b1;
      for (int i = 0; i < DEPTH; i++)
         send_item(rbq_pkg::ACT_DISPATCH, '0, 1'b0, 1'b0, '0, '0, i > 200);
      enq(32'hA000_0000);
      send_item(rbq_pkg::ACT_RESET, '0, 1'b0, 1'b0, '0, '0);
      for (int i = 0; i < DEPTH; i++)
         send_item(rbq_pkg::ACT_ACK, 32'h100 + i, 1'b1, 1'b1, 16'h1, '0, i > 230);
   endtask

   // Mostly well-formed traffic over a small ID pool so hits are common.
   task automatic test_random(input int items, input logic [rbq_pkg::CAP_W-1:0] cap);
      int k;
      logic [rbq_pkg::ID_W-1:0] id;
      set_capacity(cap);
      for (int n = 0; n < items; n++) begin
         k = $urandom_range(0, 99);
         id = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 23);
         if (k < 40) begin
            if ($urandom_range(0, 9) == 0)
               send_item(rbq_pkg::ACT_ENQUEUE, id, 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 16'($urandom_range(0, 2)),
                         16'($urandom()));
            else enq(id);
         end else if (k < 65) send_item(rbq_pkg::ACT_DISPATCH, $urandom(),
                                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                        16'($urandom()), 16'($urandom()));
         else if (k < 92) begin
            if (q_count > 0 && $urandom_range(0, 3) != 0)
               id = q_id[$urandom_range(0, q_count - 1)];
            send_item(rbq_pkg::ACT_ACK, id, $urandom_range(0, 9) != 0,
                      1'($urandom_range(0, 1)), 16'($urandom()), 16'($urandom()));
         end else send_item(rbq_pkg::ACT_RESET, $urandom(), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 16'($urandom()), 16'($urandom()));
      end
   endtask

   // Lower capacity under a queue already larger than it.
   task automatic test_shrink();
      set_capacity(9'd20);
      for (int i = 0; i < 20; i++) enq(32'h500 + i);
      set_capacity(9'd5);
      for (int i = 0; i < 6; i++) enq(32'h600 + i);
      send_item(rbq_pkg::ACT_RESET, '0, 1'b0, 1'b0, '0, '0);
   endtask

   initial begin
      q_count = 0;
      q_drops = '0;
      q_cap = '0;
      for (int i = 0; i < DEPTH; i++) q_flight[i] = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_depth();
      test_random(350, 9'd8);
      test_random(250, 9'd2);
      test_shrink();
      test_random(250, 9'd256);
      test_random(200, 9'd511);
      go_idle();
      repeat (10) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/rbq_pkg.sv
rtl/core/rbq_ctrl.sv
rtl/core/rbq_datapath.sv
rtl/core/retaining_batch_queue_core.sv
dv/tb_retaining_batch_queue_core.sv
